@@ design/cft_pkg.sv @@
// shared types and constants of the csv field tokenizer
// used by every module of the block; depends on nothing
`default_nettype none

package cft_pkg;

	// whitespace buffer
	localparam int SPACE_DEPTH = 8;
	localparam int SPC_W = $clog2(SPACE_DEPTH + 1);
	localparam int SPI_W = $clog2(SPACE_DEPTH);

	// queue sizes
	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	// field index
	localparam int IDX_W = 5;
	localparam logic [IDX_W-1:0] IDX_MAX = '1;

	// characters
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	// operation handed from front to back
	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_APPEND = 2'd1,
		OP_FIELD  = 2'd2,
		OP_LINE   = 2'd3
	} op_t;

	// result kind code
	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_FIELD = 2'd1,
		KIND_LINE  = 2'd2
	} kind_t;

	typedef struct packed {
		logic       pre_quote;
		op_t        op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data;
		logic [IDX_W-1:0] num;
		logic             ovf;
		logic             last;
	} res_t;

endpackage

`default_nettype wire

@@ design/csv_field_tokenizer_unit.sv @@
// top level of the csv field tokenizer: front, command queue, back, result queue
// depends on cft_pkg, cft_front, cft_cmd_fifo, cft_back, cft_res_fifo
//
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------------
// input    | push / full        | char_byte, end_of_line
// result   | empty / pop        | kind, out_byte, field_number, space_overflow, last
//
// the front takes one item per cycle while the 2-entry command queue has room;
// items that only change the quoting mode never reach the back
// the back plans a command only when idle, then emits its results one per cycle
// while the result queue has room; whitespace after a pending quote that releases
// held or buffered bytes delays the next plan for the whitespace buffer write
// results wait in a 4-entry queue; when it is full the back stalls, then the
// command queue fills and full rises
// reset clears quoting mode, field state, queues and sequencer; no clearing pass
`default_nettype none

module csv_field_tokenizer_unit import cft_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [7:0]       char_byte,
	input  wire logic             end_of_line,
	output logic                  empty,
	input  wire logic             pop,
	output logic [1:0]            kind,
	output logic [7:0]            out_byte,
	output logic [IDX_W-1:0]      field_number,
	output logic                  space_overflow,
	output logic                  last
);

	cmd_t cmd_in, cmd_out;
	logic cmd_push, cmd_full, cmd_pop, cmd_empty;
	res_t res_in, res_out;
	logic res_push, res_full;

	// classification and quoting
	cft_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.char_byte   (char_byte),
		.end_of_line (end_of_line),
		.full        (full),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in),
		.cmd_full    (cmd_full)
	);

	// command queue
	cft_cmd_fifo u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.empty  (cmd_empty),
		.rdata  (cmd_out)
	);

	// field state and result sequencing
	cft_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// result queue
	cft_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_out)
	);

	// result fields
	assign kind           = res_out.kind;
	assign out_byte       = res_out.data;
	assign field_number   = res_out.num;
	assign space_overflow = res_out.ovf;
	assign last           = res_out.last;

endmodule

`default_nettype wire

@@ design/cft_front.sv @@
// front part: accepts line bytes, tracks quoting, issues back commands
// depends on cft_pkg
`default_nettype none

module cft_front import cft_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [7:0] char_byte,
	input  wire logic       end_of_line,
	output logic            full,
	output logic            cmd_push,
	output cmd_t            cmd,
	input  wire logic       cmd_full
);

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_QUOTE   = 2'd1,
		MODE_PENDING = 2'd2
	} mode_t;

	mode_t mode_q;
	mode_t mode_d;
	logic  accept;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	// classify the item against the quoting mode
	always_comb begin
		mode_d        = mode_q;
		cmd.pre_quote = 1'b0;
		cmd.op        = OP_NONE;
		cmd.data      = char_byte;
		if (end_of_line) begin
			cmd.pre_quote = (mode_q == MODE_PENDING);
			cmd.op        = OP_LINE;
			mode_d        = MODE_NORMAL;
		end else begin
			unique case (mode_q)
				MODE_QUOTE: begin
					if (char_byte == CH_QUOTE) begin
						mode_d = MODE_PENDING;
					end else begin
						cmd.op = OP_APPEND;
					end
				end
				MODE_PENDING: begin
					cmd.pre_quote = 1'b1;
					if (char_byte == CH_QUOTE) begin
						mode_d = MODE_QUOTE;
					end else begin
						mode_d = MODE_NORMAL;
						cmd.op = (char_byte == CH_COMMA) ? OP_FIELD : OP_APPEND;
					end
				end
				default: begin
					if (char_byte == CH_COMMA) begin
						mode_d = MODE_NORMAL;
						cmd.op = OP_FIELD;
					end else begin
						mode_d = (char_byte == CH_QUOTE) ? MODE_QUOTE : MODE_NORMAL;
						cmd.op = OP_APPEND;
					end
				end
			endcase
		end
	end

	// items that change only the mode produce no command
	assign cmd_push = accept && (cmd.pre_quote || (cmd.op != OP_NONE));

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
		end else if (accept) begin
			mode_q <= mode_d;
		end
	end

endmodule

`default_nettype wire

@@ design/cft_cmd_fifo.sv @@
// command queue between front and back
// depends on cft_pkg
`default_nettype none

module cft_cmd_fifo import cft_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	output logic      full,
	input  wire logic pop,
	output logic      empty,
	output cmd_t      rdata
);

	cmd_t                 mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (count_q == CMD_CNT_W'(CMD_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
					: wr_ptr_q + CMD_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
					: rd_ptr_q + CMD_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CMD_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CMD_CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ design/cft_back.sv @@
// back part: field state, whitespace buffer and result sequencing
// depends on cft_pkg
`default_nettype none

module cft_back import cft_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_empty,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	input  wire logic res_full,
	output logic      res_push,
	output res_t      res
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_HOLD1  = 3'd1,
		ST_SPACES = 3'd2,
		ST_QUOTE2 = 3'd3,
		ST_TAIL   = 3'd4,
		ST_FIELD  = 3'd5,
		ST_LINE   = 3'd6
	} state_t;

	// slot mask bits: hold1, spaces, quote2, tail, field, line
	function automatic state_t first_slot(input logic [5:0] m);
		state_t s;
		begin
			priority if (m[0]) s = ST_HOLD1;
			else if (m[1]) s = ST_SPACES;
			else if (m[2]) s = ST_QUOTE2;
			else if (m[3]) s = ST_TAIL;
			else if (m[4]) s = ST_FIELD;
			else if (m[5]) s = ST_LINE;
			else s = ST_IDLE;
			return s;
		end
	endfunction

	function automatic logic [5:0] above_mask(input state_t s);
		logic [5:0] m;
		begin
			unique case (s)
				ST_HOLD1:  m = 6'b111110;
				ST_SPACES: m = 6'b111100;
				ST_QUOTE2: m = 6'b111000;
				ST_TAIL:   m = 6'b110000;
				ST_FIELD:  m = 6'b100000;
				default:   m = 6'b000000;
			endcase
			return m;
		end
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
	endfunction

	// field state
	logic             cs_q, raw_q, oqd_q, hv_q, ovf_q;
	logic [7:0]       hb_q;
	logic [SPC_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;

	// plan of the command being emitted
	state_t           state_q;
	logic [5:0]       slots_q;
	logic [SPC_W-1:0] nsp_q;
	logic [SPI_W-1:0] sidx_q;
	logic [7:0]       h1_q, tb_q;
	logic [IDX_W-1:0] fnum_q, lnum_q;
	logic             povf_q;
	logic             wr_pend_q;
	logic [7:0]       wbyte_q;
	logic [SPI_W-1:0] waddr_q;

	// whitespace buffer
	logic [7:0]       space_mem_q [SPACE_DEPTH];
	logic [7:0]       rd_q;
	logic [SPI_W-1:0] raddr;
	logic             mem_we;
	logic [SPI_W-1:0] mem_wa;
	logic [7:0]       mem_wd;

	// next field state and plan
	logic             n_cs, n_raw, n_oqd, n_hv, n_ovf;
	logic [7:0]       n_hb;
	logic [SPC_W-1:0] n_cnt, n_nsp;
	logic [IDX_W-1:0] n_idx, n_lnum;
	logic [5:0]       n_slots;
	logic [7:0]       n_tb;
	logic             n_wr, pre_flush, do_end;
	logic [SPI_W-1:0] n_wa;

	logic plan_go;
	logic advance;
	logic sp_last;
	logic no_more;

	// work out the whole command from the state at its start
	always_comb begin
		n_cs      = cs_q;
		n_raw     = raw_q;
		n_oqd     = oqd_q;
		n_hv      = hv_q;
		n_hb      = hb_q;
		n_cnt     = cnt_q;
		n_idx     = idx_q;
		n_ovf     = ovf_q;
		n_nsp     = '0;
		n_slots   = '0;
		n_tb      = hb_q;
		n_lnum    = idx_q;
		n_wr      = 1'b0;
		n_wa      = '0;
		pre_flush = 1'b0;
		do_end    = 1'b0;
		// closing quote that was waiting
		if (cmd.pre_quote) begin
			n_raw = 1'b1;
			if (!n_cs) begin
				n_cs  = 1'b1;
				n_oqd = 1'b1;
			end else begin
				n_slots[0] = n_hv;
				n_nsp      = n_cnt;
				n_cnt      = '0;
				n_hb       = CH_QUOTE;
				n_hv       = 1'b1;
				pre_flush  = 1'b1;
			end
		end
		unique case (cmd.op)
			OP_APPEND: begin
				n_raw = 1'b1;
				if (is_space(cmd.data)) begin
					if (n_cs) begin
						if (n_cnt < SPC_W'(SPACE_DEPTH)) begin
							n_wr  = 1'b1;
							n_wa  = n_cnt[SPI_W-1:0];
							n_cnt = n_cnt + SPC_W'(1);
						end else begin
							n_ovf = 1'b1;
						end
					end
				end else if (!n_cs) begin
					n_cs = 1'b1;
					if (cmd.data == CH_QUOTE) begin
						n_oqd = 1'b1;
					end else begin
						n_hb = cmd.data;
						n_hv = 1'b1;
					end
				end else begin
					if (pre_flush) begin
						n_slots[2] = n_hv;
					end else begin
						n_slots[0] = n_hv;
						n_nsp      = n_cnt;
					end
					n_cnt = '0;
					n_hb  = cmd.data;
					n_hv  = 1'b1;
				end
			end
			OP_FIELD: begin
				do_end = 1'b1;
			end
			OP_LINE: begin
				do_end     = n_raw;
				n_slots[5] = 1'b1;
			end
			default: begin
			end
		endcase
		// field end
		if (do_end) begin
			n_slots[3] = n_hv && !(n_oqd && (n_hb == CH_QUOTE));
			n_tb       = n_hb;
			n_slots[4] = 1'b1;
			if (n_idx != IDX_MAX) begin
				n_idx = n_idx + IDX_W'(1);
			end
			n_cs  = 1'b0;
			n_raw = 1'b0;
			n_oqd = 1'b0;
			n_hv  = 1'b0;
			n_hb  = '0;
			n_cnt = '0;
		end
		// line end
		if (cmd.op == OP_LINE) begin
			n_lnum = n_idx;
			n_cs   = 1'b0;
			n_raw  = 1'b0;
			n_oqd  = 1'b0;
			n_hv   = 1'b0;
			n_hb   = '0;
			n_cnt  = '0;
			n_idx  = '0;
			n_ovf  = 1'b0;
		end
		n_slots[1] = (n_nsp != '0);
	end

	assign plan_go  = (state_q == ST_IDLE) && !wr_pend_q && !cmd_empty;
	assign cmd_pop  = plan_go;
	assign res_push = (state_q != ST_IDLE) && !res_full;
	assign advance  = res_push;
	assign sp_last  = ((SPC_W'(sidx_q) + SPC_W'(1)) == nsp_q);
	assign no_more  = ((slots_q & above_mask(state_q)) == '0);

	// result of the current slot
	always_comb begin
		res.kind = KIND_BYTE;
		res.data = '0;
		res.num  = fnum_q;
		res.ovf  = povf_q;
		res.last = no_more && ((state_q != ST_SPACES) || sp_last);
		unique case (state_q)
			ST_HOLD1:  res.data = h1_q;
			ST_SPACES: res.data = rd_q;
			ST_QUOTE2: res.data = CH_QUOTE;
			ST_TAIL:   res.data = tb_q;
			ST_FIELD:  res.kind = KIND_FIELD;
			ST_LINE: begin
				res.kind = KIND_LINE;
				res.num  = lnum_q;
			end
			default: begin
			end
		endcase
	end

	// buffer write: at plan time, or after the slots when the command has any
	always_comb begin
		mem_we = 1'b0;
		mem_wa = waddr_q;
		mem_wd = wbyte_q;
		if ((state_q == ST_IDLE) && wr_pend_q) begin
			mem_we = 1'b1;
		end else if (plan_go && n_wr && (n_slots == '0)) begin
			mem_we = 1'b1;
			mem_wa = n_wa;
			mem_wd = cmd.data;
		end
	end

	// read address runs one entry ahead of the emitted space
	always_comb begin
		raddr = '0;
		if (state_q == ST_SPACES) begin
			raddr = (advance && !sp_last) ? sidx_q + SPI_W'(1) : sidx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			space_mem_q[mem_wa] <= mem_wd;
		end
		rd_q <= space_mem_q[raddr];
	end

	// plan payload
	always_ff @(posedge clk) begin
		if (plan_go) begin
			h1_q    <= hb_q;
			tb_q    <= n_tb;
			nsp_q   <= n_nsp;
			fnum_q  <= idx_q;
			lnum_q  <= n_lnum;
			povf_q  <= ovf_q;
			wbyte_q <= cmd.data;
			waddr_q <= n_wa;
		end
	end

	// sequencer and field state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			slots_q   <= '0;
			sidx_q    <= '0;
			wr_pend_q <= 1'b0;
			cs_q      <= 1'b0;
			raw_q     <= 1'b0;
			oqd_q     <= 1'b0;
			hv_q      <= 1'b0;
			hb_q      <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
			ovf_q     <= 1'b0;
		end else begin
			if (state_q == ST_IDLE) begin
				if (wr_pend_q) begin
					wr_pend_q <= 1'b0;
				end else if (plan_go) begin
					state_q   <= first_slot(n_slots);
					slots_q   <= n_slots;
					sidx_q    <= '0;
					wr_pend_q <= n_wr && (n_slots != '0);
					cs_q      <= n_cs;
					raw_q     <= n_raw;
					oqd_q     <= n_oqd;
					hv_q      <= n_hv;
					hb_q      <= n_hb;
					cnt_q     <= n_cnt;
					idx_q     <= n_idx;
					ovf_q     <= n_ovf;
				end
			end else if (advance) begin
				if ((state_q == ST_SPACES) && !sp_last) begin
					sidx_q <= sidx_q + SPI_W'(1);
				end else begin
					state_q <= first_slot(slots_q & above_mask(state_q));
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ design/cft_res_fifo.sv @@
// result queue in front of the output ports
// depends on cft_pkg
`default_nettype none

module cft_res_fifo import cft_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t wdata,
	output logic      full,
	input  wire logic pop,
	output logic      empty,
	output res_t      rdata
);

	res_t                 mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_CNT_W-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (count_q == RES_CNT_W'(RES_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == RES_PTR_W'(RES_DEPTH - 1)) ? '0
					: wr_ptr_q + RES_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == RES_PTR_W'(RES_DEPTH - 1)) ? '0
					: rd_ptr_q + RES_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + RES_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - RES_CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire
